// ===== src/tbp_pkg.sv =====
// Package for the tournament branch predictor: table sizes, counter codes,
// request and result structs, saturating counter helper. No dependencies.
`timescale 1ns / 1ps
package tbp_pkg;

  localparam int GHIST_BITS    = 12;
  localparam int LHIST_BITS    = 10;
  localparam int PC_INDEX_BITS = 10;

  // clearing sweep covers the deepest table
  localparam int CLR_BITS =
    (GHIST_BITS >= LHIST_BITS && GHIST_BITS >= PC_INDEX_BITS) ? GHIST_BITS :
    (LHIST_BITS >= PC_INDEX_BITS) ? LHIST_BITS : PC_INDEX_BITS;

  typedef logic [GHIST_BITS-1:0]    gh_t;
  typedef logic [LHIST_BITS-1:0]    lh_t;
  typedef logic [PC_INDEX_BITS-1:0] slot_t;
  typedef logic [1:0]               ctr_t;

  localparam ctr_t CTR_MAX     = 2'd3;
  localparam ctr_t CTR_MIN     = 2'd0;
  localparam ctr_t CTR_WEAK_NT = 2'd1;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] pc;
    logic        outcome;
  } in_t;

  typedef struct packed {
    logic prediction;
    logic chose_local;
  } out_t;

  // saturating 2-bit counter step
  function automatic ctr_t ctr_move(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== src/tournament_branch_predictor_unit.sv =====
// Tournament branch predictor top level: global/chooser table, local history
// table and local counter table in synchronous RAMs. Depends on tbp_pkg.
`timescale 1ns / 1ps
// Usage
//   Request channel: drive in_data and raise start; the request is taken at a
//   rising edge where start is high and busy is low. operation selects predict
//   (no state change) or train (update with in_data.outcome).
//   Result channel: out_valid pulses for one cycle with out_data holding the
//   prediction as it stood before any update and which side the chooser took.
//   The receiver has no back pressure; every result must be captured on its
//   strobe cycle.
// Timing
//   A taken request reads the global/chooser and history RAMs, then in S_LH
//   the counter RAM at that history; S_LC predicts and writes back, and the
//   result strobe is registered from it. busy is low in S_LC, so the next
//   request can be taken there; its RAM reads overlap this write-back, and
//   same-entry collisions on global/chooser and history RAMs are forwarded.
// Reset
//   rst_n (synchronous, active low) clears the global history and starts a
//   clearing sweep over 2**CLR_BITS addresses (4096 here) that sets all
//   counters to weakly not taken and all local histories to zero. busy stays
//   high during the sweep.
module tournament_branch_predictor_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  tbp_pkg::in_t in_data,
  output logic         out_valid,
  output tbp_pkg::out_t out_data
);
  import tbp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LH   = 2'd1;  // history RAM data back, read counter
  localparam logic [1:0] S_LC   = 2'd2;  // all data back, predict and write

  localparam int GDEPTH = 1 << GHIST_BITS;
  localparam int LDEPTH = 1 << LHIST_BITS;
  localparam int PDEPTH = 1 << PC_INDEX_BITS;

  // Global-history indexed RAM holds {chooser, global counter}
  logic [3:0] mem_a [GDEPTH];
  lh_t        mem_b [PDEPTH];   // local histories
  ctr_t       mem_c [LDEPTH];   // local counters

  logic [1:0]          state_r, state_nxt;
  logic                clearing_r;
  logic [CLR_BITS-1:0] clr_cnt_r;
  gh_t                 gh_r, gh_nxt;

  // captured request
  logic  op_r, tk_r;
  slot_t slot_r;
  lh_t   lh_r;

  // RAM read data and forwarding
  logic [3:0] a_rd_r, a_byp_d_r, a_q;
  logic       a_byp_r;
  lh_t        b_rd_r, b_byp_d_r, b_q;
  logic       b_byp_r;
  ctr_t       c_rd_r;

  // write ports
  logic       a_we, b_we, c_we;
  gh_t        a_waddr;
  slot_t      b_waddr;
  lh_t        c_waddr;
  logic [3:0] a_wdata;
  lh_t        b_wdata;
  ctr_t       c_wdata;

  logic  accept, commit;
  slot_t in_slot;
  ctr_t  gctr, chctr, lctr, ch_new;
  logic  gpred, lpred, use_local;

  logic out_valid_r;
  out_t out_data_r;

  assign busy    = clearing_r | (state_r == S_LH);
  assign accept  = start & ~busy;
  assign commit  = (state_r == S_LC) & (op_r == OP_TRAIN);
  assign in_slot = in_data.pc[PC_INDEX_BITS-1:0];

  // Prediction from the pre-update counters
  assign a_q       = a_byp_r ? a_byp_d_r : a_rd_r;
  assign b_q       = b_byp_r ? b_byp_d_r : b_rd_r;
  assign gctr      = a_q[1:0];
  assign chctr     = a_q[3:2];
  assign lctr      = c_rd_r;
  assign gpred     = gctr[1];
  assign lpred     = lctr[1];
  assign use_local = chctr[1];

  always_comb begin
    ch_new = chctr;
    if (gpred == tk_r && lpred != tk_r) ch_new = ctr_move(chctr, 1'b0);
    else if (lpred == tk_r && gpred != tk_r) ch_new = ctr_move(chctr, 1'b1);
  end

  assign gh_nxt = commit ? gh_t'({gh_r, tk_r}) : gh_r;

  // Write ports: clearing sweep or train write-back
  always_comb begin
    if (clearing_r) begin
      a_we    = 1'b1;
      b_we    = 1'b1;
      c_we    = 1'b1;
      a_waddr = clr_cnt_r[GHIST_BITS-1:0];
      b_waddr = clr_cnt_r[PC_INDEX_BITS-1:0];
      c_waddr = clr_cnt_r[LHIST_BITS-1:0];
      a_wdata = {CTR_WEAK_NT, CTR_WEAK_NT};
      b_wdata = '0;
      c_wdata = CTR_WEAK_NT;
    end else begin
      a_we    = commit;
      b_we    = commit;
      c_we    = commit;
      a_waddr = gh_r;
      b_waddr = slot_r;
      c_waddr = lh_r;
      a_wdata = {ch_new, ctr_move(gctr, tk_r)};
      b_wdata = lh_t'({lh_r, tk_r});
      c_wdata = ctr_move(lctr, tk_r);
    end
  end

  // RAM A: read on accept at the (possibly just updated) history
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (accept) begin
      a_rd_r    <= mem_a[gh_nxt];
      a_byp_r   <= a_we && (a_waddr == gh_nxt);
      a_byp_d_r <= a_wdata;
    end
  end

  // RAM B: local history read on accept
  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    if (accept) begin
      b_rd_r    <= mem_b[in_slot];
      b_byp_r   <= b_we && (b_waddr == in_slot);
      b_byp_d_r <= b_wdata;
    end
  end

  // RAM C: local counter read in S_LH, after any earlier write landed
  always_ff @(posedge clk) begin
    if (c_we) mem_c[c_waddr] <= c_wdata;
    if (state_r == S_LH) c_rd_r <= mem_c[b_q];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LH;
      S_LH:    state_nxt = S_LC;
      S_LC:    state_nxt = accept ? S_LH : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      gh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gh_r        <= gh_nxt;
      out_valid_r <= (state_r == S_LC);
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) clearing_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.operation;
      tk_r   <= in_data.outcome;
      slot_r <= in_slot;
    end
    if (state_r == S_LH) lh_r <= b_q;
    if (state_r == S_LC) begin
      out_data_r.prediction  <= use_local ? lpred : gpred;
      out_data_r.chose_local <= use_local;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_lh_then_lc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LH |=> state_r == S_LC)
    else $error("history stage not followed by counter stage");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_LC)
    else $error("result strobe without a finished request");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> busy && state_r == S_IDLE)
    else $error("request activity during clearing sweep");

  a_gh_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(gh_r))
    else $error("global history changed without a train write-back");

endmodule

// ===== test/tbp_prediction_checker.sv =====
// Result checker for the tournament branch predictor: mirrors the global, chooser
// and local tables per accepted request and matches every result strobe in order.
// Depends on tbp_pkg.
`timescale 1ns / 1ps
module tbp_prediction_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  tbp_pkg::in_t  in_data,
  input  logic          out_valid,
  input  tbp_pkg::out_t out_data,
  output int            fail_count,
  output int            outstanding
);
  import tbp_pkg::*;

  localparam int GSIZE = 1 << GHIST_BITS;
  localparam int LSIZE = 1 << LHIST_BITS;
  localparam int PSIZE = 1 << PC_INDEX_BITS;

  gh_t  ghist;
  ctr_t gctr    [GSIZE];
  ctr_t chooser [GSIZE];
  lh_t  lhist   [PSIZE];
  ctr_t lctr    [LSIZE];

  out_t expected_q [$];
  int   mismatches = 0;
  int   pending    = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending;

  function automatic ctr_t saturate_toward(ctr_t c, logic taken);
    if (taken) return (c == CTR_MAX) ? c : ctr_t'(c + 2'd1);
    return (c == CTR_MIN) ? c : ctr_t'(c - 2'd1);
  endfunction

  task automatic clear_tables();
    ghist = '0;
    foreach (gctr[i]) begin
      gctr[i]    = CTR_WEAK_NT;
      chooser[i] = CTR_WEAK_NT;
    end
    foreach (lhist[i]) lhist[i] = '0;
    foreach (lctr[i]) lctr[i] = CTR_WEAK_NT;
  endtask

  // prediction comes from the tables as they stand; train then updates them
  task automatic predict_and_train(input in_t req);
    slot_t slot;
    gh_t   gh;
    lh_t   lh;
    logic  gpred;
    logic  lpred;
    logic  pick_local;
    out_t  res;
    slot       = req.pc[PC_INDEX_BITS-1:0];
    gh         = ghist;
    lh         = lhist[slot];
    gpred      = gctr[gh][1];
    lpred      = lctr[lh][1];
    pick_local = chooser[gh][1];
    res.prediction  = pick_local ? lpred : gpred;
    res.chose_local = pick_local;
    expected_q.push_back(res);
    if (req.operation == OP_TRAIN) begin
      if (gpred == req.outcome && lpred != req.outcome)
        chooser[gh] = saturate_toward(chooser[gh], 1'b0);
      else if (lpred == req.outcome && gpred != req.outcome)
        chooser[gh] = saturate_toward(chooser[gh], 1'b1);
      gctr[gh]    = saturate_toward(gctr[gh], req.outcome);
      lctr[lh]    = saturate_toward(lctr[lh], req.outcome);
      ghist       = gh_t'({gh, req.outcome});
      lhist[slot] = lh_t'({lh, req.outcome});
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: prediction %0b chose_local %0b",
             got.prediction, got.chose_local);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (got.prediction !== want.prediction) begin
        $error("prediction: expected %0b, got %0b", want.prediction, got.prediction);
        mismatches++;
      end
      if (got.chose_local !== want.chose_local) begin
        $error("chose_local: expected %0b, got %0b", want.chose_local, got.chose_local);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      expected_q.delete();
    end else begin
      if (out_valid) check_result(out_data);
      if (start && !busy) predict_and_train(in_data);
    end
    pending <= expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the tournament branch predictor regression: clock, reset, request
// stimulus and verdict. Depends on tbp_pkg, tbp_prediction_checker and the DUT.
`timescale 1ns / 1ps
module testbench;
  import tbp_pkg::*;

  localparam int PHASE_ITEMS = 650;     // three phases of random requests
  localparam int POOL        = 8;       // branches that follow a repeating pattern
  localparam int DRAIN       = 8;       // quiet cycles after the last result
  localparam int CYCLE_LIMIT = 200000;  // clearing sweep plus slowest run, many times over
  localparam logic [31:0] SLOT_MASK = (32'd1 << PC_INDEX_BITS) - 32'd1;

  logic clk;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;

  // pattern branches: fixed slot, outcome repeats with a short period
  logic [31:0] pool_pc      [POOL];
  logic [3:0]  pool_pattern [POOL];
  int          pool_period  [POOL];
  int          pool_step    [POOL];

  tournament_branch_predictor_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  tbp_prediction_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tournament_branch_predictor_unit regression: fail");
      $finish;
    end
  end

  function automatic in_t make_req(input logic op, input logic [31:0] pc, input logic taken);
    in_t r;
    r.operation = op;
    r.pc        = pc;
    r.outcome   = taken;
    return r;
  endfunction

  // Called at a rising edge. Optionally holds start low for a random number of
  // cycles, then presents the request and returns at the edge that takes it
  // (start high, busy low). busy is sampled as it stood before the edge.
  task automatic send_request(input in_t req, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic shuffle_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_pc[i]      = $urandom;
      pool_pattern[i] = 4'($urandom_range(15));
      pool_period[i]  = $urandom_range(1, 4);
      pool_step[i]    = 0;
    end
  endtask

  // Mostly trains on the pattern branches so the local side learns and the
  // chooser swings toward it; the rest is predicts and random trains that
  // disturb the global history and reach arbitrary table entries.
  function automatic in_t next_random_req();
    int          k;
    int          pick;
    logic        taken;
    logic [31:0] pc;
    k    = $urandom_range(POOL - 1);
    pick = $urandom_range(99);
    // upper PC bits are ignored by the block; vary them half the time
    pc = $urandom_range(1) ? pool_pc[k]
                           : (($urandom & ~SLOT_MASK) | (pool_pc[k] & SLOT_MASK));
    if (pick < 70) begin
      taken = pool_pattern[k][pool_step[k] % pool_period[k]];
      pool_step[k]++;
      if ($urandom_range(99) < 10) taken = ~taken;  // noise
      return make_req(OP_TRAIN, pc, taken);
    end
    if (pick < 85) begin
      if ($urandom_range(1)) pc = $urandom;
      return make_req(OP_PREDICT, pc, 1'($urandom_range(1)));
    end
    return make_req(OP_TRAIN, $urandom, 1'($urandom_range(1)));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the block stays busy through its clearing sweep; send_request waits it out

    // directed: PC extremes, outcome ignored on predict, upper PC bits aliasing
    send_request(make_req(OP_PREDICT, 32'h0000_0000, 1'b0), 0);
    send_request(make_req(OP_PREDICT, 32'hFFFF_FFFF, 1'b1), 0);
    send_request(make_req(OP_TRAIN,   32'h0000_0000, 1'b1), 0);
    send_request(make_req(OP_TRAIN,   32'hFFFF_FFFF, 1'b0), 0);
    send_request(make_req(OP_TRAIN,   SLOT_MASK,     1'b1), 0);
    send_request(make_req(OP_PREDICT, ~SLOT_MASK,    1'b1), 0);
    send_request(make_req(OP_PREDICT, 32'hAAAA_AAAA, 1'b0), 0);
    send_request(make_req(OP_TRAIN,   32'h5555_5555, 1'b1), 0);
    // train one branch taken, predict it, then train it not taken
    for (int i = 0; i < 5; i++)
      send_request(make_req(OP_TRAIN, 32'h1234_5678, 1'b1), 0);
    send_request(make_req(OP_PREDICT, 32'h1234_5678, 1'b0), 0);
    for (int i = 0; i < 5; i++)
      send_request(make_req(OP_TRAIN, 32'h1234_5678, 1'b0), 0);
    send_request(make_req(OP_PREDICT, 32'hFFFF_FE78, 1'b1), 0);
    // alternating branch: local side beats global, chooser moves
    for (int i = 0; i < 4; i++)
      send_request(make_req(OP_TRAIN, 32'h0000_0040, 1'(i % 2)), 0);

    // random: light sender idling, then heavy, then back to back
    shuffle_pool();
    for (int i = 0; i < PHASE_ITEMS; i++) send_request(next_random_req(), 6);
    shuffle_pool();
    for (int i = 0; i < PHASE_ITEMS; i++) send_request(next_random_req(), 71);
    shuffle_pool();
    for (int i = 0; i < PHASE_ITEMS; i++) send_request(next_random_req(), 0);

    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tournament_branch_predictor_unit regression: pass");
    end else begin
      $display("tournament_branch_predictor_unit regression: fail");
    end
    $finish;
  end

endmodule
